### rtl/dctb_pkg.sv
// ----------------------------------------------------------------------------
// Daisy chain topology builder package
// Shared sizes, the stored triple layout and the sequencer states.
// ----------------------------------------------------------------------------
package dctb_pkg;

    localparam int MAX_CHAIN = 16;
    localparam int IDX_W     = $clog2(MAX_CHAIN);
    localparam int CNT_W     = $clog2(MAX_CHAIN + 1);
    localparam int ID_W      = 8;
    localparam int NBR_W     = 9;

    localparam logic [NBR_W-1:0] NO_NEIGHBOR_ID = '1;

    typedef struct packed {
        logic [NBR_W-1:0] slave;
        logic [ID_W-1:0]  id;
        logic [NBR_W-1:0] master;
    } triple_t;

    localparam int TRIPLE_W = $bits(triple_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCAN,
        ST_P_WAIT,
        ST_C_READ,
        ST_C_WAIT,
        ST_APPEND,
        ST_T_WAIT,
        ST_REMOVE,
        ST_RM_WAIT,
        ST_DONE
    } state_t;

endpackage

### rtl/daisy_chain_topology_builder.sv
// ----------------------------------------------------------------------------
// Daisy chain topology builder
// Orders nodes into a chain from neighbor reports kept in a pending store.
// ----------------------------------------------------------------------------
// A read word passes through a wait state and the done state before its
// result sits in the output register. A report runs a scan of the pending
// store against the chain store; each examined entry is compared with the
// chain entries in turn, and each removal shifts the later entries of the
// store down by one. The scan is repeated once for every append it makes.
// One word is in work at a time; the next is taken as soon as the result
// sits in the output register. Reset (synchronous, active low) seeds the
// chain with the root, empties the pending store and clears the output; no
// clearing pass is needed.
module daisy_chain_topology_builder
    import dctb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: root node id.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // Input words. tdata: master_id[8:0], node_id[16:9], slave_id[25:17],
    // entry_index[29:26], zero fill. tuser: kind.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    // Result words. tdata: chain_length[4:0], pending_count[9:5],
    // dropped[10], read_id[19:11], zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    state_t state_reg, state_next;

    logic [ID_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0] ccount_reg, ccount_next;
    logic [CNT_W-1:0] ptotal_reg, ptotal_next;
    logic             e0_valid_reg, e0_valid_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] cix_reg, cix_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             restart_reg, restart_next;
    logic             c_rd0_reg, c_rd0_next;
    triple_t          p_reg, p_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             dropped_reg, dropped_next;
    logic [NBR_W-1:0] rid_reg, rid_next;
    logic             m_valid_reg, m_valid_next;
    logic [23:0]      m_data_reg, m_data_next;

    // Memory ports.
    logic             p_we, c_we;
    logic [IDX_W-1:0] p_waddr, p_raddr, c_waddr, c_raddr;
    triple_t          p_wdata, c_wdata;
    logic [TRIPLE_W-1:0] p_rdata, c_rdata;

    dctb_ram #(.WIDTH(TRIPLE_W), .DEPTH(MAX_CHAIN)) u_pending (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    dctb_ram #(.WIDTH(TRIPLE_W), .DEPTH(MAX_CHAIN)) u_chain (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // Until entry 0 is written after a reseed, it reads as the root seed.
    triple_t seed, c_el;
    assign seed = '{slave: NO_NEIGHBOR_ID, id: root_reg, master: NO_NEIGHBOR_ID};
    assign c_el = (c_rd0_reg && !e0_valid_reg) ? seed : triple_t'(c_rdata);

    logic accept, id_hit, is_err, is_dup, take_ok, rm_more, load_out, c_more;
    assign accept   = s_tvalid && s_tready;
    assign id_hit   = p_reg.id == c_el.id;
    // An unknown master on a node other than the root is ignored.
    assign is_err   = (p_reg.master == NO_NEIGHBOR_ID) && (p_reg.id != root_reg);
    assign is_dup   = (p_reg.master == c_el.master) && (p_reg.slave == c_el.slave);
    assign c_more   = cix_reg < ccount_reg;
    // In the tail wait, a report extends the tail; on an empty chain only the
    // root report may start it.
    assign take_ok  = ((state_reg == ST_T_WAIT)
                       ? ((c_el.slave == {1'b0, p_reg.id}) &&
                          ({1'b0, c_el.id} == p_reg.master))
                       : (p_reg.id == root_reg))
                      && (ccount_reg < CNT_W'(MAX_CHAIN));
    assign rm_more  = CNT_W'(k_reg + 1'b1) < ptotal_reg;
    assign load_out = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept) state_next = s_tuser ? ST_READ_WAIT : ST_SCAN;
            ST_READ_WAIT: state_next = ST_DONE;
            ST_SCAN:      state_next = (scan_reg == '0) ? ST_DONE : ST_P_WAIT;
            ST_P_WAIT:    state_next = ST_C_READ;
            ST_C_READ:    state_next = c_more ? ST_C_WAIT : ST_APPEND;
            ST_C_WAIT: begin
                if (!id_hit) begin
                    state_next = ST_C_READ;
                end else if (!is_err && is_dup) begin
                    state_next = ST_REMOVE;
                end else begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                if (ccount_reg != '0) begin
                    state_next = ST_T_WAIT;
                end else begin
                    state_next = take_ok ? ST_REMOVE : ST_SCAN;
                end
            end
            ST_T_WAIT:    state_next = take_ok ? ST_REMOVE : ST_SCAN;
            ST_REMOVE:    state_next = rm_more ? ST_RM_WAIT : ST_SCAN;
            ST_RM_WAIT:   state_next = ST_REMOVE;
            ST_DONE:      if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and the output register.
    always_comb begin
        root_next     = root_reg;
        ccount_next   = ccount_reg;
        ptotal_next   = ptotal_reg;
        e0_valid_next = e0_valid_reg;
        scan_next     = scan_reg;
        pos_next      = pos_reg;
        cix_next      = cix_reg;
        k_next        = k_reg;
        restart_next  = restart_reg;
        c_rd0_next    = c_rd0_reg;
        p_next        = p_reg;
        idx_next      = idx_reg;
        dropped_next  = dropped_reg;
        rid_next      = rid_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        p_we    = 1'b0;
        p_waddr = ptotal_reg[IDX_W-1:0];
        p_wdata = triple_t'(s_tdata[TRIPLE_W-1:0]);
        p_raddr = '0;
        c_we    = 1'b0;
        c_waddr = ccount_reg[IDX_W-1:0];
        c_wdata = p_reg;
        c_raddr = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next     = s_tdata[29:26];
                    c_raddr      = s_tdata[29:26];
                    c_rd0_next   = (s_tdata[29:26] == '0);
                    rid_next     = NO_NEIGHBOR_ID;
                    dropped_next = 1'b0;
                    scan_next    = ptotal_reg;
                    if (!s_tuser) begin
                        if (ptotal_reg < CNT_W'(MAX_CHAIN)) begin
                            p_we        = 1'b1;
                            ptotal_next = ptotal_reg + 1'b1;
                            scan_next   = ptotal_reg + 1'b1;
                        end else begin
                            dropped_next = 1'b1;
                        end
                    end
                end
            end
            ST_READ_WAIT: begin
                if ({1'b0, idx_reg} < ccount_reg) begin
                    rid_next = {1'b0, c_el.id};
                end
            end
            ST_SCAN: begin
                if (scan_reg != '0) begin
                    scan_next = scan_reg - 1'b1;
                    pos_next  = IDX_W'(scan_reg - 1'b1);
                    p_raddr   = IDX_W'(scan_reg - 1'b1);
                end
            end
            ST_P_WAIT: begin
                p_next   = triple_t'(p_rdata);
                cix_next = '0;
            end
            ST_C_READ: begin
                c_raddr    = cix_reg[IDX_W-1:0];
                c_rd0_next = (cix_reg == '0);
            end
            ST_C_WAIT: begin
                if (!id_hit) begin
                    cix_next = cix_reg + 1'b1;
                end else if (!is_err) begin
                    if (is_dup) begin
                        k_next       = {1'b0, pos_reg};
                        restart_next = 1'b0;
                    end else begin
                        // A changed report cuts the chain back to this node.
                        ccount_next = cix_reg;
                    end
                end
            end
            ST_APPEND, ST_T_WAIT: begin
                if (state_reg == ST_APPEND && ccount_reg != '0) begin
                    c_raddr    = IDX_W'(ccount_reg - 1'b1);
                    c_rd0_next = (ccount_reg == CNT_W'(1));
                end else if (take_ok) begin
                    c_we        = 1'b1;
                    ccount_next = ccount_reg + 1'b1;
                    if (ccount_reg == '0) begin
                        e0_valid_next = 1'b1;
                    end
                    k_next       = {1'b0, pos_reg};
                    restart_next = 1'b1;
                end
            end
            ST_REMOVE: begin
                if (rm_more) begin
                    p_raddr = IDX_W'(k_reg + 1'b1);
                end else begin
                    ptotal_next = ptotal_reg - 1'b1;
                    // An append restarts from the newest entry; a duplicate
                    // removal goes on below the removed entry.
                    scan_next   = restart_reg ? CNT_W'(ptotal_reg - 1'b1)
                                              : {1'b0, pos_reg};
                end
            end
            ST_RM_WAIT: begin
                p_we    = 1'b1;
                p_waddr = k_reg[IDX_W-1:0];
                p_wdata = triple_t'(p_rdata);
                k_next  = k_reg + 1'b1;
            end
            ST_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, rid_reg, dropped_reg, ptotal_reg, ccount_reg};
                end
            end
            default: begin
            end
        endcase

        // A root write reseeds the chain; the user must write it only while idle, as the block does not enforce this.
        if (cfg_we) begin
            root_next     = cfg_wdata;
            ccount_next   = CNT_W'(1);
            e0_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            root_reg     <= '0;
            ccount_reg   <= CNT_W'(1);
            ptotal_reg   <= '0;
            e0_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            root_reg     <= root_next;
            ccount_reg   <= ccount_next;
            ptotal_reg   <= ptotal_next;
            e0_valid_reg <= e0_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        pos_reg     <= pos_next;
        cix_reg     <= cix_next;
        k_reg       <= k_next;
        restart_reg <= restart_next;
        c_rd0_reg   <= c_rd0_next;
        p_reg       <= p_next;
        idx_reg     <= idx_next;
        dropped_reg <= dropped_next;
        rid_reg     <= rid_next;
        m_data_reg  <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ptotal_reg <= CNT_W'(MAX_CHAIN))
        else $error("pending store count beyond its depth");

    a_chain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ccount_reg <= CNT_W'(MAX_CHAIN))
        else $error("chain count beyond its depth");

    a_drop_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[19:11] == NO_NEIGHBOR_ID))
        else $error("dropped report carries a read id");
`endif

endmodule

### rtl/dctb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### verif/tb_daisy_chain_topology_builder.sv
// ----------------------------------------------------------------------------
// Daisy chain topology builder testbench
// Drives report and read words with random gaps and back pressure, predicts
// chain length, pending count, drop flag and read id in a behavioral model,
// and compares each result word against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_daisy_chain_topology_builder;
    import dctb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 20000000;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic [8:0] read_id;
        logic       dropped;
        logic [4:0] pending_count;
        logic [4:0] chain_length;
    } outcome_t;

    typedef struct {
        logic        kind;
        logic [31:0] data;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    daisy_chain_topology_builder uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // Model state: the ordered chain and the store of pending reports.
    logic [7:0] model_root;
    triple_t    chain_q[MAX_CHAIN];
    int         chain_len;
    triple_t    pend_q[MAX_CHAIN];
    int         pend_len;

    word_t      send_q[$];
    outcome_t   outcome_q[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         accepted = 0;
    int         results_seen = 0;

    function automatic int sx9(logic [8:0] v);
        return $signed(v);
    endfunction

    function automatic void reseed_chain();
        chain_q[0] = '{slave: NO_NEIGHBOR_ID, id: model_root, master: NO_NEIGHBOR_ID};
        chain_len = 1;
    endfunction

    function automatic void drop_pending(int pos);
        for (int k = pos; k + 1 < pend_len; k++) pend_q[k] = pend_q[k + 1];
        pend_len--;
    endfunction

    // Tries one pending entry against the chain: 0 kept, 1 appended, 2 duplicate.
    function automatic int try_entry(int pos);
        triple_t p;
        bit take;
        p = pend_q[pos];
        for (int ix = 0; ix < chain_len; ix++) begin
            if (p.id == chain_q[ix].id) begin
                if (sx9(p.master) == -1 && p.id != model_root) begin
                    // Unknown master on a non-root node is ignored.
                end else if (p.master == chain_q[ix].master && p.slave == chain_q[ix].slave) begin
                    drop_pending(pos);
                    return 2;
                end else begin
                    chain_len = ix;
                end
                break;
            end
        end
        if (chain_len > 0)
            take = (sx9(chain_q[chain_len-1].slave) == int'(p.id)) &&
                   (int'(chain_q[chain_len-1].id) == sx9(p.master));
        else
            take = (p.id == model_root);
        if (take && chain_len < MAX_CHAIN) begin
            chain_q[chain_len] = p;
            chain_len++;
            return 1;
        end
        return 0;
    endfunction

    function automatic outcome_t predict_outcome(word_t w);
        outcome_t o;
        bit again;
        int i;
        o = '0;
        o.read_id = '1;
        if (w.kind == KIND_REPORT) begin
            if (pend_len >= MAX_CHAIN) begin
                o.dropped = 1'b1;
            end else begin
                pend_q[pend_len] = '{slave: w.data[25:17], id: w.data[16:9],
                                     master: w.data[8:0]};
                pend_len++;
            end
            // Rescan from the newest entry after every append.
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                i = pend_len;
                while (i > 0) begin
                    i--;
                    if (try_entry(i) == 1) begin
                        drop_pending(i);
                        again = 1'b1;
                        break;
                    end
                end
            end
        end else if (int'(w.data[29:26]) < chain_len) begin
            o.read_id = {1'b0, chain_q[w.data[29:26]].id};
        end
        o.chain_length = chain_len[4:0];
        o.pending_count = pend_len[4:0];
        return o;
    endfunction

    function automatic word_t make_report(int m, int n, int s);
        word_t w;
        w.kind = KIND_REPORT;
        w.data = {2'b00, 4'($urandom_range(0, 15)), 9'(s), 8'(n), 9'(m)};
        return w;
    endfunction

    function automatic word_t make_read(int idx);
        word_t w;
        w.kind = KIND_READ;
        // Junk in the report fields checks that a read ignores them.
        w.data = {2'b00, 4'(idx), 26'($urandom)};
        return w;
    endfunction

    // Driver: one word at a time, with a random gap before each. A word
    // counts as taken once the acceptance counter has moved past it.
    int send_gap = 0;
    int send_taken = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (accepted != send_taken) begin
                // The word was taken at the last rising edge.
                send_taken = accepted;
                void'(send_q.pop_front());
                send_gap = $urandom_range(0, 12);
                if (send_gap == 0 && send_q.size() > 0) begin
                    s_tdata <= send_q[0].data;
                    s_tuser <= send_q[0].kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (send_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= send_q[0].data;
                    s_tuser <= send_q[0].kind;
                end
            end
        end
    end

    // Predict at the acceptance edge so the model follows word order.
    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && s_tvalid && s_tready) begin
            word_t w;
            w.kind = s_tuser;
            w.data = s_tdata;
            outcome_q.push_back(predict_outcome(w));
            accepted++;
        end
    end

    // Monitor: compare each taken result word with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outcome_t got, want;
            got = m_tdata[19:0];
            results_seen++;
            if (outcome_q.size() == 0) begin
                $error("result word with no prediction waiting: %h", m_tdata);
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got.chain_length != want.chain_length) begin
                    $error("chain_length expected %0d actual %0d", want.chain_length,
                           got.chain_length);
                    fail_count++;
                end
                if (got.pending_count != want.pending_count) begin
                    $error("pending_count expected %0d actual %0d", want.pending_count,
                           got.pending_count);
                    fail_count++;
                end
                if (got.dropped != want.dropped) begin
                    $error("dropped expected %0d actual %0d", want.dropped, got.dropped);
                    fail_count++;
                end
                if (got.read_id != want.read_id) begin
                    $error("read_id expected %0d actual %0d", sx9(want.read_id),
                           sx9(got.read_id));
                    fail_count++;
                end
            end
        end
    end

    // Receiver back pressure: a random stall before each result word.
    int recv_gap = 0;
    int recv_taken = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != recv_taken) begin
                recv_taken = results_seen;
                recv_gap = $urandom_range(0, 12);
                if (recv_gap != 0) m_tready <= 1'b0;
            end else if (!m_tready) begin
                if (recv_gap > 0) recv_gap--;
                else m_tready <= 1'b1;
            end
        end
    end

    // Timeout guard.
    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Waits until the driver has sent everything and all results are back.
    task automatic drain();
        while (send_q.size() > 0 || s_tvalid || outcome_q.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // Writes the root register while the block is idle and reseeds the model.
    task automatic write_root(logic [7:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        model_root = value;
        reseed_chain();
    endtask

    // Pushes a well-formed chain run from the current root with random length,
    // often shuffled, and sometimes corrupted, plus reads.
    task automatic queue_chain_run(int len);
        int ids[$];
        word_t run[$];
        int m, s;
        ids.push_back(model_root);
        while (ids.size() < len + 1) begin
            int c = $urandom_range(0, 254);
            if (!(c inside {ids})) ids.push_back(c);
        end
        for (int k = 1; k <= len; k++) begin
            m = ids[k-1];
            s = (k < len) ? ids[k+1] : -1;
            run.push_back(make_report(m, ids[k], s));
        end
        run.push_front(make_report(-1, model_root, ids.size() > 1 ? ids[1] : -1));
        if ($urandom_range(0, 1)) run.shuffle();
        if ($urandom_range(0, 3) == 0 && run.size() > 0)
            run[$urandom_range(0, run.size() - 1)].data[8:0] = 9'($urandom);
        foreach (run[k]) send_q.push_back(run[k]);
        repeat ($urandom_range(1, 3)) send_q.push_back(make_read($urandom_range(0, 15)));
    endtask

    initial begin
        word_t w;
        model_root = 8'd0;
        pend_len = 0;
        reseed_chain();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reads at both ends, a chain, a duplicate, an ignored
        // unknown master, a cut, odd negative ids, then nearly filling the store.
        send_q.push_back(make_read(0));
        send_q.push_back(make_read(15));
        send_q.push_back(make_report(0, 5, 7));
        send_q.push_back(make_report(0, 5, 7));
        send_q.push_back(make_report(-1, 5, 9));
        send_q.push_back(make_report(0, 5, 8));
        send_q.push_back(make_report(-1, 0, 5));
        send_q.push_back(make_report(-256, 254, 254));
        send_q.push_back(make_report(254, 0, -256));
        send_q.push_back(make_read(1));
        drain();
        write_root(8'd254);
        for (int k = 0; k < 14; k++) send_q.push_back(make_report(200 + k, 100 + k, 255));
        send_q.push_back(make_read(0));
        drain();

        // Random phases with changing root, extremes among them.
        for (int ph = 0; ph < 16; ph++) begin
            write_root(ph == 0 ? 8'd0 : ph == 1 ? 8'd254 : 8'($urandom_range(0, 254)));
            while (send_q.size() < 125) begin
                case ($urandom_range(0, 5))
                    0, 1, 2: queue_chain_run($urandom_range(1, 15));
                    3: send_q.push_back(make_read($urandom_range(0, 15)));
                    default: begin
                        w = make_report(int'($urandom_range(0, 511)) - 256,
                                        $urandom_range(0, 255),
                                        int'($urandom_range(0, 511)) - 256);
                        send_q.push_back(w);
                    end
                endcase
            end
            drain();
        end

        $display("Ran %0d words through %0d root settings; %0d result words checked.",
                 accepted, 18, results_seen);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### daisy_chain_topology_builder.f
rtl/dctb_pkg.sv
rtl/dctb_ram.sv
rtl/daisy_chain_topology_builder.sv
verif/tb_daisy_chain_topology_builder.sv
